### hw/rtl/cqd_pkg.sv
// Shared types and constants of the circular queue with dump.
package cqd_pkg;

    localparam int OP_W     = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int QSIZE_W  = 7;

    localparam logic [QSIZE_W-1:0] QSIZE_RST = 7'd64;

    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP    = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] value;
    } t_cmd;

endpackage

### hw/rtl/cqd_if.sv
// Valid/ready channel interfaces for commands and responses.
interface cqd_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [cqd_pkg::OP_W-1:0]          operation;
    logic signed [cqd_pkg::WORD_W-1:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface cqd_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [cqd_pkg::STATUS_W-1:0]      status;
    logic signed [cqd_pkg::WORD_W-1:0] word_out;
    logic                              last;

    modport source (output valid, output status, output word_out, output last, input ready);
    modport sink   (input valid, input status, input word_out, input last, output ready);
endinterface

### hw/rtl/circular_queue_with_dump.sv
// Top level of the circular queue with dump: size register, front end and back end.
//
// Commands arrive on i_cmd: enqueue stores push_value, dequeue removes the
// oldest word, and dump lists every stored word from oldest to newest.
// Responses leave on o_rsp, each with a status, a word and a last flag that
// marks the final response of a command. Code 3 is taken and dropped silently.
// The usable size is written through i_cfg_we and i_cfg_data; the user is to do so only while idle,
// which the block does not enforce. Zero acts as one and values above DEPTH act as DEPTH.
// A command transfer lands in a two-entry command buffer, and the back end takes
// it from the buffer's registered entries. An enqueue answer then passes through
// the response register; a dequeue answer first passes through the storage
// RAM's registered read port. Enqueues run at one per cycle while o_rsp.ready
// stays high; a dequeue or dump, one RAM read per word, blocks new commands until its last word.
// Reset clears the pointers and the occupancy and sets the size to 64; the
// stored words are not cleared and no clearing pass is needed.
// When the receiver stalls, the response register holds its transfer and the
// back end waits; the command buffer still takes up to two more commands
// before i_cmd.ready falls.
module circular_queue_with_dump #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cqd_cmd_if.sink                      i_cmd,
    cqd_rsp_if.source                    o_rsp,
    input  logic                         i_cfg_we,
    input  logic [cqd_pkg::QSIZE_W-1:0]  i_cfg_data
);
    import cqd_pkg::*;

    logic [QSIZE_W-1:0] r_queue_size;
    logic               cmd_valid;
    logic               cmd_ready;
    t_cmd               cmd;

    // The size register is only to be written while the block is idle; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_size <= QSIZE_RST;
        end else if (i_cfg_we) begin
            r_queue_size <= i_cfg_data;
        end
    end

    cqd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    cqd_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_queue_size (r_queue_size),
        .i_cmd_valid  (cmd_valid),
        .o_cmd_ready  (cmd_ready),
        .i_cmd        (cmd),
        .o_rsp        (o_rsp)
    );
endmodule

### hw/rtl/cqd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/cqd_front.sv
// Front end: accepts commands, drops unused codes and buffers two commands.
module cqd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cqd_cmd_if.sink        i_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready,
    output cqd_pkg::t_cmd  o_cmd
);
    import cqd_pkg::*;

    t_cmd       r_ent [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       push, pop;

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign push = i_cmd.valid && i_cmd.ready && (i_cmd.operation != OP_NONE);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop  = o_cmd_valid && i_cmd_ready;
    assign o_cmd = r_ent[r_rptr];

    always_comb begin
        n_wptr = push ? ~r_wptr : r_wptr;
        n_rptr = pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wptr] <= '{op: i_cmd.operation, value: i_cmd.push_value};
        end
    end
endmodule

### hw/rtl/cqd_back.sv
// Back end: carries out enqueue, dequeue and dump against the storage RAM.
module cqd_back #(
    parameter int DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cqd_pkg::QSIZE_W-1:0]   i_queue_size,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  cqd_pkg::t_cmd                 i_cmd,
    cqd_rsp_if.source                     o_rsp
);
    import cqd_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [IDX_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_occ, n_occ;
    logic [IDX_W-1:0]   r_walk, n_walk;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic               r_valid, n_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [WORD_W-1:0]  r_word, n_word;
    logic               r_last, n_last;

    logic [CNT_W-1:0]   eff;
    logic               out_free;
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                             input logic [CNT_W-1:0] sz);
        logic [SUM_W-1:0] nxt;
        nxt = SUM_W'(idx) + SUM_W'(1);
        if (nxt >= SUM_W'(sz)) begin
            return '0;
        end
        return IDX_W'(nxt);
    endfunction

    always_comb begin
        if (i_queue_size == '0) begin
            eff = CNT_W'(1);
        end else if (i_queue_size > QSIZE_W'(DEPTH)) begin
            eff = CNT_W'(DEPTH);
        end else begin
            eff = CNT_W'(i_queue_size);
        end
    end

    assign out_free = !r_valid || o_rsp.ready;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_occ     = r_occ;
        n_walk    = r_walk;
        n_rem     = r_rem;
        n_valid   = r_valid && !o_rsp.ready;
        n_status  = r_status;
        n_word    = r_word;
        n_last    = r_last;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_walk;
        o_cmd_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_ready = 1'b1;
                    unique case (i_cmd.op)
                        OP_ENQUEUE: begin
                            n_valid = 1'b1;
                            n_word  = '0;
                            n_last  = 1'b1;
                            if (r_occ >= eff) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status = ST_OK;
                                ram_we   = 1'b1;
                                n_tail   = adv(r_tail, eff);
                                n_occ    = r_occ + CNT_W'(1);
                            end
                        end
                        OP_DEQUEUE, OP_DUMP: begin
                            if (r_occ == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                                n_word   = '0;
                                n_last   = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = r_head;
                                n_walk    = adv(r_head, eff);
                                n_state   = S_READ;
                                if (i_cmd.op == OP_DEQUEUE) begin
                                    n_rem  = CNT_W'(1);
                                    n_head = adv(r_head, eff);
                                    n_occ  = r_occ - CNT_W'(1);
                                end else begin
                                    n_rem  = r_occ;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_word   = ram_rdata;
                    n_last   = (r_rem == CNT_W'(1));
                    if (r_rem == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_walk;
                        n_walk    = adv(r_walk, eff);
                        n_rem     = r_rem - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    cqd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (i_cmd.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk   <= n_walk;
        r_rem    <= n_rem;
        r_status <= n_status;
        r_word   <= n_word;
        r_last   <= n_last;
    end

    assign o_rsp.valid    = r_valid;
    assign o_rsp.status   = r_status;
    assign o_rsp.word_out = r_word;
    assign o_rsp.last     = r_last;
endmodule

### hw/rtl/cqd_checker.sv
// Port-level assertions for the circular queue with dump, and their binding.
module cqd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [cqd_pkg::STATUS_W-1:0]  i_rsp_status,
    input logic [cqd_pkg::WORD_W-1:0]    i_rsp_word,
    input logic                          i_rsp_last
);
    import cqd_pkg::*;

    // A pending response is not withdrawn.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response withdrawn before transfer");

    // Reset leaves no response pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response pending after reset");

    // A full answer carries no word and ends its command.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_FULL |-> i_rsp_word == '0 && i_rsp_last)
        else $error("full response malformed");

    // An empty answer carries no word and ends its command.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_EMPTY |-> i_rsp_word == '0 && i_rsp_last)
        else $error("empty response malformed");
endmodule

bind circular_queue_with_dump cqd_checker u_cqd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_word   (o_rsp.word_out),
    .i_rsp_last   (o_rsp.last)
);

### sim/testbench.sv
// Self-checking testbench for the circular queue with dump, with its own prediction of every response.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cqd_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 9;
    localparam int DEPTH          = 64;
    // Settling time after the last predicted response, ample for a dropped
    // code 3 command to leave the pipeline.
    localparam int SETTLE_CYCLES  = 8;
    localparam int STALL_CYCLES   = 120;
    localparam int WATCHDOG_LIMIT = 600;

    // One predicted response, kept in arrival order.
    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] word;
        logic                     last;
    } t_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [QSIZE_W-1:0]   i_cfg_data;

    cqd_cmd_if cmd_ch ();
    cqd_rsp_if rsp_ch ();

    circular_queue_with_dump #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Our own copy of the queue: stored words, pointers, occupancy and size.
    logic signed [WORD_W-1:0] queue_words [DEPTH];
    int                       head_slot;
    int                       tail_slot;
    int                       stored_count;
    logic [QSIZE_W-1:0]       size_reg;

    t_answer pending_answers [$];

    int error_count   = 0;
    int quiet_cycles  = 0;
    int rsp_wait      = 0;
    int stall_left    = 0;
    bit idle_on       = 1'b1;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // A size of zero behaves as one and anything above the depth as the depth.
    function automatic int active_size();
        if (size_reg == '0) begin
            return 1;
        end
        if (size_reg > DEPTH) begin
            return DEPTH;
        end
        return int'(size_reg);
    endfunction

    function automatic int next_slot(input int slot);
        slot++;
        if (slot >= active_size()) begin
            slot = 0;
        end
        return slot;
    endfunction

    function automatic void queue_answer(input logic [STATUS_W-1:0] status,
                                         input logic signed [WORD_W-1:0] word,
                                         input logic last);
        t_answer a;
        a.status = status;
        a.word   = word;
        a.last   = last;
        pending_answers.push_back(a);
    endfunction

    // Applies one accepted command to the local queue and records the responses
    // it must produce.
    function automatic void predict_answers(input logic [OP_W-1:0] op,
                                            input logic signed [WORD_W-1:0] value);
        int slot;
        case (op)
            OP_ENQUEUE: begin
                // Occupancy may exceed a freshly shrunk size; that still counts as full.
                if (stored_count >= active_size()) begin
                    queue_answer(ST_FULL, '0, 1'b1);
                end else begin
                    queue_words[tail_slot] = value;
                    tail_slot = next_slot(tail_slot);
                    stored_count++;
                    queue_answer(ST_OK, '0, 1'b1);
                end
            end
            OP_DEQUEUE: begin
                if (stored_count == 0) begin
                    queue_answer(ST_EMPTY, '0, 1'b1);
                end else begin
                    queue_answer(ST_OK, queue_words[head_slot], 1'b1);
                    head_slot = next_slot(head_slot);
                    stored_count--;
                end
            end
            OP_DUMP: begin
                if (stored_count == 0) begin
                    queue_answer(ST_EMPTY, '0, 1'b1);
                end else begin
                    slot = head_slot;
                    for (int k = 0; k < stored_count; k++) begin
                        queue_answer(ST_OK, queue_words[slot], k == stored_count - 1);
                        slot = next_slot(slot);
                    end
                end
            end
            default: begin
                // The unused code is dropped without any response.
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    function automatic void compare_field(input string field,
                                          input logic signed [WORD_W-1:0] expected,
                                          input logic signed [WORD_W-1:0] actual);
        if (actual !== expected) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field, expected, actual);
            error_count++;
        end
    endfunction

    // Each response transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected response: expected none, actual status %0d word %0d last %0d",
                         $time, rsp_ch.status, rsp_ch.word_out, rsp_ch.last);
                error_count++;
            end else begin
                a = pending_answers.pop_front();
                compare_field("status", a.status, rsp_ch.status);
                compare_field("word_out", a.word, rsp_ch.word_out);
                compare_field("last", a.last, rsp_ch.last);
            end
            rsp_wait = idle_on ? $urandom_range(0, 10) : 0;
        end
    end

    // The receiver lowers ready for the drawn wait after each transfer, and for
    // a long stretch when the pressure test asks for it.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
        end else if (rsp_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait--;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // A run in which nothing moves for too long has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d responses outstanding",
                         $time, pending_answers.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Offers one command after a drawn gap and returns at the edge where it is
    // taken. Valid stays high afterwards so that back-to-back commands need no
    // second assignment in the same step.
    task automatic send_command(input logic [OP_W-1:0] op,
                                input logic signed [WORD_W-1:0] value);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.operation  <= op;
        cmd_ch.push_value <= value;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_answers(op, value);
    endtask

    // Drops valid, waits until every predicted response has arrived and then
    // gives any silently dropped command time to leave the block.
    task automatic wait_settled();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_queue_size(input logic [QSIZE_W-1:0] value);
        wait_settled();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        size_reg = value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15);
            1: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_operation();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return OP_ENQUEUE;
        end
        if (r < 85) begin
            return OP_DEQUEUE;
        end
        if (r < 95) begin
            return OP_DUMP;
        end
        return OP_NONE;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset the queue is empty at the full size, and the unused
    // code must produce nothing at all.
    task automatic test_empty_queue();
        send_command(OP_DEQUEUE, 32'sd5);
        send_command(OP_DUMP, '0);
        send_command(OP_NONE, 32'sh7fffffff);
    endtask

    // A size of zero behaves as one entry; then one entry written as such.
    task automatic test_single_entry();
        write_queue_size(7'd0);
        send_command(OP_ENQUEUE, 32'sh7fffffff);
        send_command(OP_ENQUEUE, 32'sd1);
        send_command(OP_DUMP, '0);
        send_command(OP_DEQUEUE, '0);
        send_command(OP_DEQUEUE, '0);
        write_queue_size(7'd1);
        send_command(OP_ENQUEUE, 32'sh80000000);
        send_command(OP_DEQUEUE, '0);
    endtask

    // Word extremes and alternating patterns through a small queue, including
    // full on enqueue, a dump of a full queue and a dump of an empty one.
    task automatic test_word_extremes();
        write_queue_size(7'd5);
        send_command(OP_ENQUEUE, '0);
        send_command(OP_ENQUEUE, -32'sd1);
        send_command(OP_ENQUEUE, 32'sh55555555);
        send_command(OP_ENQUEUE, 32'shaaaaaaaa);
        send_command(OP_ENQUEUE, 32'sh80000000);
        send_command(OP_ENQUEUE, 32'sh7fffffff);
        send_command(OP_DUMP, '0);
        repeat (5) send_command(OP_DEQUEUE, '0);
        send_command(OP_DUMP, '0);
    endtask

    // A size above the depth acts as the depth. Filling all 64 slots here also
    // means no later read can land on a slot that was never written.
    task automatic test_full_depth();
        write_queue_size(7'd127);
        repeat (DEPTH) send_command(OP_ENQUEUE, pick_word());
        send_command(OP_ENQUEUE, 32'sd9);
        send_command(OP_NONE, '0);
        send_command(OP_DUMP, '0);
        repeat (DEPTH / 2) send_command(OP_DEQUEUE, '0);
    endtask

    // Shrinking the size below the occupancy: enqueues report full until enough
    // words have gone, and the pointers wrap under the new size.
    task automatic test_shrink_with_words();
        write_queue_size(7'd6);
        send_command(OP_ENQUEUE, 32'sd3);
        send_command(OP_DUMP, '0);
        repeat (28) send_command(OP_DEQUEUE, '0);
        repeat (3) send_command(OP_ENQUEUE, pick_word());
        send_command(OP_DUMP, '0);
        repeat (8) send_command(OP_DEQUEUE, '0);
    endtask

    // The receiver holds off for a long stretch while commands keep coming, so
    // the block fills its buffers and stalls its input.
    task automatic test_output_stall();
        write_queue_size(7'd64);
        idle_on = 1'b0;
        @(posedge i_clk);
        stall_left = STALL_CYCLES;
        repeat (24) send_command(OP_ENQUEUE, pick_word());
        send_command(OP_DUMP, '0);
        repeat (25) send_command(OP_DEQUEUE, '0);
        idle_on = 1'b1;
    endtask

    // Random traffic in phases, each with its own size, some with idling on
    // both sides and some without.
    task automatic test_random_traffic();
        logic [QSIZE_W-1:0] phase_size [7];
        phase_size = '{7'd2, 7'd0, 7'd100, 7'($urandom_range(1, 8)),
                       7'($urandom_range(0, 127)), 7'd64, 7'd3};
        for (int p = 0; p < 7; p++) begin
            write_queue_size(phase_size[p]);
            idle_on = (p % 3 != 2);
            repeat (20) send_command(pick_operation(), pick_word());
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_data        = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.operation  = OP_NONE;
        cmd_ch.push_value = '0;
        rsp_ch.ready      = 1'b0;
        head_slot         = 0;
        tail_slot         = 0;
        stored_count      = 0;
        size_reg          = QSIZE_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_single_entry();
        test_word_extremes();
        test_full_depth();
        test_shrink_with_words();
        test_output_stall();
        test_random_traffic();

        wait_settled();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
